@@ sv/ahtks_pkg.sv @@
// Shared types, constants and character map for the ASCII to HID keystroke sequencer.
`timescale 1ns / 1ps
`default_nettype none
package ahtks_pkg;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] MOD_NONE   = 2'd0;
    localparam logic [1:0] MOD_LSHIFT = 2'd2;

    localparam logic [7:0] USAGE_NONE  = 8'h00;
    localparam logic [7:0] USAGE_CAPS  = 8'h39;
    localparam logic [7:0] USAGE_NUM   = 8'h53;
    localparam logic [7:0] USAGE_ENTER = 8'h28;
    localparam logic [7:0] USAGE_A     = 8'h04;
    localparam logic [7:0] USAGE_KP1   = 8'h59;
    localparam logic [7:0] USAGE_KP0   = 8'h62;
    localparam logic [7:0] USAGE_SPACE = 8'h2C;
    localparam logic [7:0] USAGE_SLASH = 8'h38;

    localparam int LED_NUM_BIT  = 0;
    localparam int LED_CAPS_BIT = 1;

    localparam int MAX_STROKES = 3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] character;
        logic [7:0] lock_leds;
    } t_in_item;

    typedef struct packed {
        logic [1:0] modifier;
        logic [7:0] key_code;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] key;
        logic       shift;
    } t_stroke;

    typedef struct packed {
        logic [1:0]                    count;
        t_stroke [MAX_STROKES-1:0]     strokes;
    } t_job;

    function automatic t_stroke map_char(input logic [7:0] c);
        t_stroke s;
        s.key   = USAGE_NONE;
        s.shift = 1'b0;
        if (c >= "a" && c <= "z") begin
            s.key = USAGE_A + (c - 8'("a"));
        end else if (c >= "A" && c <= "Z") begin
            s.key   = USAGE_A + (c - 8'("A"));
            s.shift = 1'b1;
        end else if (c >= "1" && c <= "9") begin
            s.key = USAGE_KP1 + (c - 8'("1"));
        end else begin
            unique case (c)
                8'("0"):  s.key = USAGE_KP0;
                8'(" "):  s.key = USAGE_SPACE;
                8'("/"):  s.key = USAGE_SLASH;
                8'("?"):  begin s.key = USAGE_SLASH; s.shift = 1'b1; end
                8'("!"):  begin s.key = 8'h1E; s.shift = 1'b1; end
                8'("@"):  begin s.key = 8'h1F; s.shift = 1'b1; end
                8'("#"):  begin s.key = 8'h20; s.shift = 1'b1; end
                8'("$"):  begin s.key = 8'h21; s.shift = 1'b1; end
                8'("%"):  begin s.key = 8'h22; s.shift = 1'b1; end
                8'("^"):  begin s.key = 8'h23; s.shift = 1'b1; end
                8'("&"):  begin s.key = 8'h24; s.shift = 1'b1; end
                8'("*"):  begin s.key = 8'h25; s.shift = 1'b1; end
                8'("("):  begin s.key = 8'h26; s.shift = 1'b1; end
                8'(")"):  begin s.key = 8'h27; s.shift = 1'b1; end
                8'h2D:    s.key = 8'h2D;
                8'h3D:    s.key = 8'h2E;
                8'h5B:    s.key = 8'h2F;
                8'h5D:    s.key = 8'h30;
                8'h5C:    s.key = 8'h31;
                8'h3B:    s.key = 8'h33;
                8'h27:    s.key = 8'h34;
                8'h60:    s.key = 8'h35;
                8'h2C:    s.key = 8'h36;
                8'h2E:    s.key = 8'h37;
                8'h5F:    begin s.key = 8'h2D; s.shift = 1'b1; end
                8'h2B:    begin s.key = 8'h2E; s.shift = 1'b1; end
                8'h7B:    begin s.key = 8'h2F; s.shift = 1'b1; end
                8'h7D:    begin s.key = 8'h30; s.shift = 1'b1; end
                8'h7C:    begin s.key = 8'h31; s.shift = 1'b1; end
                8'h3A:    begin s.key = 8'h33; s.shift = 1'b1; end
                8'h22:    begin s.key = 8'h34; s.shift = 1'b1; end
                8'h7E:    begin s.key = 8'h35; s.shift = 1'b1; end
                8'h3C:    begin s.key = 8'h36; s.shift = 1'b1; end
                8'h3E:    begin s.key = 8'h37; s.shift = 1'b1; end
                default: begin
                    s.key   = USAGE_NONE;
                    s.shift = 1'b0;
                end
            endcase
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ sv/ahtks_front.sv @@
// Front end: accepts items, tracks lock and run state, builds keystroke jobs.
`timescale 1ns / 1ps
`default_nettype none
module ahtks_front
    import ahtks_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_job          o_job,
    output logic          o_job_valid
);

    logic r_caps_was_on, n_caps_was_on;
    logic r_num_was_off, n_num_was_off;
    logic r_typed_any,   n_typed_any;

    t_stroke [MAX_STROKES-1:0] cand;
    logic    [MAX_STROKES-1:0] cand_valid;
    t_stroke                   mapped;
    t_job                      job;
    logic    [1:0]             cnt;

    assign mapped = map_char(i_item.character);

    always_comb begin
        n_caps_was_on = r_caps_was_on;
        n_num_was_off = r_num_was_off;
        n_typed_any   = r_typed_any;
        cand          = '0;
        cand_valid    = '0;
        unique case (i_item.operation)
            OP_START: begin
                n_caps_was_on  = i_item.lock_leds[LED_CAPS_BIT];
                n_num_was_off  = ~i_item.lock_leds[LED_NUM_BIT];
                n_typed_any    = 1'b0;
                cand[0]        = '{key: USAGE_CAPS, shift: 1'b0};
                cand_valid[0]  = i_item.lock_leds[LED_CAPS_BIT];
                cand[1]        = '{key: USAGE_NUM, shift: 1'b0};
                cand_valid[1]  = ~i_item.lock_leds[LED_NUM_BIT];
            end
            OP_CHAR: begin
                n_typed_any   = 1'b1;
                cand[0]       = mapped;
                cand_valid[0] = (mapped.key != USAGE_NONE);
            end
            OP_FINISH: begin
                n_caps_was_on = 1'b0;
                n_num_was_off = 1'b0;
                n_typed_any   = 1'b0;
                cand[0]       = '{key: USAGE_ENTER, shift: 1'b0};
                cand_valid[0] = r_typed_any;
                cand[1]       = '{key: USAGE_CAPS, shift: 1'b0};
                cand_valid[1] = r_caps_was_on;
                cand[2]       = '{key: USAGE_NUM, shift: 1'b0};
                cand_valid[2] = r_num_was_off;
            end
            default: begin
                cand_valid = '0;
            end
        endcase
    end

    // pack the present strokes to the bottom slots, keeping order
    always_comb begin
        job = '0;
        cnt = 2'd0;
        for (int k = 0; k < MAX_STROKES; k++) begin
            if (cand_valid[k]) begin
                job.strokes[cnt] = cand[k];
                cnt              = cnt + 2'd1;
            end
        end
        job.count = cnt;
    end

    assign o_job       = job;
    assign o_job_valid = i_accept && (cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps_was_on <= 1'b0;
            r_num_was_off <= 1'b0;
            r_typed_any   <= 1'b0;
        end else if (i_accept) begin
            r_caps_was_on <= n_caps_was_on;
            r_num_was_off <= n_num_was_off;
            r_typed_any   <= n_typed_any;
        end
    end

endmodule
`default_nettype wire

@@ sv/ahtks_job_queue.sv @@
// Two-entry job queue between the front end and the report generator.
`timescale 1ns / 1ps
`default_nettype none
module ahtks_job_queue
    import ahtks_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job r_slot0, r_slot1;
    logic r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_rd_ptr ? r_slot1 : r_slot0;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            if (r_wr_ptr) begin
                r_slot1 <= i_job;
            end else begin
                r_slot0 <= i_job;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/ahtks_back.sv @@
// Back end: walks each job's strokes and emits press and release reports.
`timescale 1ns / 1ps
`default_nettype none
module ahtks_back
    import ahtks_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_empty,
    output logic      o_job_pop,
    output t_out_item o_result,
    output logic      o_empty,
    input  wire logic i_pop
);

    logic      r_out_valid;
    t_out_item r_out, n_out;
    logic [1:0] r_idx, n_idx;
    logic      r_release, n_release;
    t_stroke   cur;
    logic      advance, emit, last_stroke;

    always_comb begin
        unique case (r_idx)
            2'd0:    cur = i_job.strokes[0];
            2'd1:    cur = i_job.strokes[1];
            2'd2:    cur = i_job.strokes[2];
            default: cur = '0;
        endcase
    end

    assign advance     = !r_out_valid || i_pop;
    assign emit        = advance && !i_job_empty;
    assign last_stroke = (r_idx == (i_job.count - 2'd1));

    always_comb begin
        n_out      = r_out;
        n_idx      = r_idx;
        n_release  = r_release;
        o_job_pop  = 1'b0;
        if (emit) begin
            if (!r_release) begin
                n_out.modifier = cur.shift ? MOD_LSHIFT : MOD_NONE;
                n_out.key_code = cur.key;
                n_out.last     = 1'b0;
                n_release      = 1'b1;
            end else begin
                n_out.modifier = MOD_NONE;
                n_out.key_code = USAGE_NONE;
                n_out.last     = last_stroke;
                n_release      = 1'b0;
                if (last_stroke) begin
                    n_idx     = 2'd0;
                    o_job_pop = 1'b1;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_release   <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_release <= n_release;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

endmodule
`default_nettype wire

@@ sv/ascii_to_hid_keystroke_sequencer.sv @@
// Top level of the ASCII to USB HID keyboard report sequencer (US layout).
// Items go in through a push/full port and reports come out through an
// empty/pop port. A start item yields up to two lock-toggle keystrokes, a
// character one keystroke or none, a finish item up to three; each
// keystroke is a press report then an all-zero release report, and the final
// report of an item carries last. The report generator produces one report
// per cycle while the result side pops and a job is queued; the front end
// keeps accepting while a two-job queue and the output register absorb
// stalls on the result side.
`timescale 1ns / 1ps
`default_nettype none
module ascii_to_hid_keystroke_sequencer
    import ahtks_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_item,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_result
);

    t_job job_in, job_head;
    logic job_valid, q_full, q_empty, q_pop;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    ahtks_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_job       (job_in),
        .o_job_valid (job_valid)
    );

    ahtks_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_head),
        .o_empty (q_empty)
    );

    ahtks_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the ASCII to HID keystroke sequencer: directed and random items.
`timescale 1ns / 1ps
module tb;
    import ahtks_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         TAIL_CYCLES = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    logic [7:0] key_tab [256];
    logic       shift_tab [256];

    t_out_item reports_due [$];
    logic      caps_was_lit;
    logic      num_was_dark;
    logic      chars_since_start;
    logic      steady;
    int        mismatch_count;
    int        cycle_count;

    ascii_to_hid_keystroke_sequencer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic void set_key(input logic [7:0] c, input logic [7:0] key,
                                    input logic sh);
        key_tab[c]   = key;
        shift_tab[c] = sh;
    endfunction

    function automatic void build_key_table();
        string row;
        for (int i = 0; i < 256; i++) begin
            set_key(8'(i), USAGE_NONE, 1'b0);
        end
        for (int i = 0; i < 26; i++) begin
            set_key(8'("a") + 8'(i), USAGE_A + 8'(i), 1'b0);
            set_key(8'("A") + 8'(i), USAGE_A + 8'(i), 1'b1);
        end
        for (int i = 0; i < 9; i++) begin
            set_key(8'("1") + 8'(i), USAGE_KP1 + 8'(i), 1'b0);
        end
        set_key("0", USAGE_KP0, 1'b0);
        set_key(" ", USAGE_SPACE, 1'b0);
        set_key("/", USAGE_SLASH, 1'b0);
        set_key("?", USAGE_SLASH, 1'b1);
        row = "!@#$%^&*()";
        for (int i = 0; i < 10; i++) begin
            set_key(row[i], 8'h1E + 8'(i), 1'b1);
        end
        set_key("-", 8'h2D, 1'b0);
        set_key("_", 8'h2D, 1'b1);
        set_key("=", 8'h2E, 1'b0);
        set_key("+", 8'h2E, 1'b1);
        set_key("[", 8'h2F, 1'b0);
        set_key("{", 8'h2F, 1'b1);
        set_key("]", 8'h30, 1'b0);
        set_key("}", 8'h30, 1'b1);
        set_key(8'h5C, 8'h31, 1'b0);
        set_key("|", 8'h31, 1'b1);
        set_key(";", 8'h33, 1'b0);
        set_key(":", 8'h33, 1'b1);
        set_key(8'h27, 8'h34, 1'b0);
        set_key(8'h22, 8'h34, 1'b1);
        set_key(8'h60, 8'h35, 1'b0);
        set_key("~", 8'h35, 1'b1);
        set_key(",", 8'h36, 1'b0);
        set_key("<", 8'h36, 1'b1);
        set_key(".", 8'h37, 1'b0);
        set_key(">", 8'h37, 1'b1);
    endfunction

    function automatic void add_keystroke(input logic [7:0] key, input logic sh);
        t_out_item r;
        r.modifier = sh ? MOD_LSHIFT : MOD_NONE;
        r.key_code = key;
        r.last     = 1'b0;
        reports_due.push_back(r);
        r.modifier = MOD_NONE;
        r.key_code = USAGE_NONE;
        reports_due.push_back(r);
    endfunction

    function automatic void predict_reports(input t_in_item it);
        int        old_size;
        t_out_item r;
        old_size = reports_due.size();
        case (it.operation)
            OP_START: begin
                caps_was_lit      = it.lock_leds[LED_CAPS_BIT];
                num_was_dark      = !it.lock_leds[LED_NUM_BIT];
                chars_since_start = 1'b0;
                if (caps_was_lit) add_keystroke(USAGE_CAPS, 1'b0);
                if (num_was_dark) add_keystroke(USAGE_NUM, 1'b0);
            end
            OP_CHAR: begin
                chars_since_start = 1'b1;
                if (key_tab[it.character] != USAGE_NONE) begin
                    add_keystroke(key_tab[it.character], shift_tab[it.character]);
                end
            end
            OP_FINISH: begin
                if (chars_since_start) add_keystroke(USAGE_ENTER, 1'b0);
                if (caps_was_lit) add_keystroke(USAGE_CAPS, 1'b0);
                if (num_was_dark) add_keystroke(USAGE_NUM, 1'b0);
                caps_was_lit      = 1'b0;
                num_was_dark      = 1'b0;
                chars_since_start = 1'b0;
            end
            default: begin
            end
        endcase
        if (reports_due.size() > old_size) begin
            r = reports_due.pop_back();
            r.last = 1'b1;
            reports_due.push_back(r);
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [7:0] leds);
        t_in_item it;
        it.operation = op;
        it.character = ch;
        it.lock_leds = leds;
        if (!steady && $urandom_range(0, 5) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_item = it;
        push   = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_reports(it);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic wait_drained();
        while (reports_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_lock_states();
        send_item(OP_START, 8'h00, 8'h02);
        send_item(OP_FINISH, 8'h00, 8'h00);
        send_item(OP_START, 8'hFF, 8'hFF);
        send_item(OP_CHAR, "q", 8'h00);
        send_item(OP_FINISH, 8'hFF, 8'hFF);
    endtask

    task automatic test_char_extremes();
        send_item(OP_START, 8'h00, 8'h01);
        send_item(OP_CHAR, "a", 8'h00);
        send_item(OP_CHAR, "Z", 8'hFF);
        send_item(OP_CHAR, "0", 8'h00);
        send_item(OP_CHAR, "9", 8'h00);
        send_item(OP_CHAR, "?", 8'h00);
        send_item(OP_CHAR, "@", 8'h00);
        send_item(OP_CHAR, "^", 8'h00);
        send_item(OP_CHAR, "*", 8'h00);
        send_item(OP_CHAR, 8'h27, 8'h00);
        send_item(OP_CHAR, 8'h60, 8'h00);
        send_item(OP_CHAR, 8'h00, 8'h00);
        send_item(OP_CHAR, 8'hFF, 8'h00);
        send_item(OP_FINISH, 8'h00, 8'h00);
    endtask

    task automatic test_odd_sequences();
        send_item(OP_CHAR, "~", 8'h00);
        send_item(OP_START, 8'h00, 8'h00);
        send_item(OP_START, 8'h41, 8'hFD);
        send_item(OP_FINISH, 8'h00, 8'h00);
        send_item(OP_FINISH, 8'h00, 8'h00);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
    endtask

    task automatic test_pause_until_drained();
        send_item(OP_START, 8'h00, 8'h02);
        send_item(OP_CHAR, "H", 8'h00);
        send_item(OP_CHAR, "i", 8'h00);
        wait_drained();
        send_item(OP_CHAR, "!", 8'h00);
        send_item(OP_FINISH, 8'h00, 8'h00);
        wait_drained();
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 7) begin
            return 8'($urandom_range(8'h20, 8'h7E));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_random_strings(input int item_goal);
        int         sent;
        int         len;
        logic [1:0] op;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(0, 12);
                send_item(OP_START, pick_char(), 8'($urandom_range(0, 255)));
                for (int i = 0; i < len; i++) begin
                    send_item(OP_CHAR, pick_char(), 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(OP_FINISH, pick_char(), 8'($urandom_range(0, 255)));
                    sent++;
                end
                sent += len + 1;
            end else begin
                op = 2'($urandom_range(0, 3));
                send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected report: expected none, got mod=%0d key=%02h last=%0d",
                         $time, o_result.modifier, o_result.key_code, o_result.last);
                mismatch_count++;
            end else begin
                want = reports_due.pop_front();
                if (o_result.modifier !== want.modifier || o_result.key_code !== want.key_code
                        || o_result.last !== want.last) begin
                    $display("%0t: report mismatch: expected mod=%0d key=%02h last=%0d, got mod=%0d key=%02h last=%0d",
                             $time, want.modifier, want.key_code, want.last,
                             o_result.modifier, o_result.key_code, o_result.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!steady && $urandom_range(0, 11) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            pop = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        push              = 1'b0;
        i_item            = '0;
        steady            = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        caps_was_lit      = 1'b0;
        num_was_dark      = 1'b0;
        chars_since_start = 1'b0;
        build_key_table();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_lock_states();
        test_char_extremes();
        test_odd_sequences();
        test_pause_until_drained();
        test_random_strings(130);
        steady = 1'b1;
        test_random_strings(50);

        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && reports_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ahtks_pkg.sv
sv/ahtks_front.sv
sv/ahtks_job_queue.sv
sv/ahtks_back.sv
sv/ascii_to_hid_keystroke_sequencer.sv
bench/tb.sv
